// ----- rtl/skn_pkg.sv -----
// ----------------------------------------------------------------------------
// skn_pkg
// Shared types and constants for the sorted key node: word layouts,
// command, result and status codes, controller states and control bundles.
// ----------------------------------------------------------------------------
package skn_pkg;

  // node geometry
  localparam int MAX_KEYS  = 8;
  localparam int KEY_WIDTH = 32;
  localparam int SLOTS     = MAX_KEYS + 1;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int IDX_W     = $clog2(SLOTS);

  // fixed field widths of the words
  localparam int CMD_W  = 2;
  localparam int KIND_W = 2;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_SPLIT  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_REPLY = 2'd0,
    KIND_SEP   = 2'd1,
    KIND_MOVED = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC,
    ST_OUT
  } state_t;

  // command word
  typedef struct packed {
    logic [CMD_W-1:0]            command;
    logic signed [KEY_WIDTH-1:0] key;
  } cmd_word_t;

  // result word
  typedef struct packed {
    logic [KIND_W-1:0]           result_kind;
    logic signed [KEY_WIDTH-1:0] key_out;
    logic [POS_W-1:0]            position;
    logic                        found;
    logic [CNT_W-1:0]            key_count;
    logic                        needs_split;
    logic [STAT_W-1:0]           status;
    logic                        last;
  } res_word_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic load_cmp;
    logic exec;
    logic emit_next;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic out_last;
  } stat_t;

endpackage

// ----- rtl/skn_ctrl.sv -----
// ----------------------------------------------------------------------------
// skn_ctrl
// Sequencer for the sorted key node: accept, compare, execute, then hand
// out result words until the one marked last is taken.
// ----------------------------------------------------------------------------
module skn_ctrl
  import skn_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_ready,
  output logic  res_valid,
  input  logic  res_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_CMP;
      end
      ST_CMP:  state_next = ST_EXEC;
      ST_EXEC: state_next = ST_OUT;
      ST_OUT: begin
        if (res_ready && stat.out_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_ready      = (state == ST_IDLE);
    res_valid      = (state == ST_OUT);
    ctrl.load_in   = (state == ST_IDLE) && cmd_valid;
    ctrl.load_cmp  = (state == ST_CMP);
    ctrl.exec      = (state == ST_EXEC);
    ctrl.emit_next = (state == ST_OUT) && res_ready && !stat.out_last;
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd_ready && res_valid))
    else $error("command taken while a result word is pending");

  a_cmp_to_exec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |=> (state == ST_EXEC))
    else $error("compare step not followed by execute");
`endif

endmodule

// ----- rtl/skn_datapath.sv -----
// ----------------------------------------------------------------------------
// skn_datapath
// Key slots, key count, parallel compare against the held key, shift
// insert, split cursor and the result word register.
// ----------------------------------------------------------------------------
module skn_datapath
  import skn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_word_t cmd_word,
  input  ctrl_t     ctrl,
  output stat_t     stat,
  output res_word_t res_word
);

  logic signed [KEY_WIDTH-1:0] keys [SLOTS];
  logic [CNT_W-1:0]            total;
  cmd_e                        cmd_q;
  logic signed [KEY_WIDTH-1:0] key_q;
  logic [CNT_W-1:0]            rank;
  logic                        match;
  logic [CNT_W-1:0]            cursor;
  logic [CNT_W-1:0]            split_end;
  logic [POS_W-1:0]            move_idx;
  res_word_t                   res_q;

  logic [SLOTS-1:0]            le_vec;
  logic [SLOTS-1:0]            eq_vec;
  logic [CNT_W-1:0]            rank_calc;
  logic [CNT_W-1:0]            keep;
  logic [CNT_W-1:0]            cursor_inc;

  // compare every occupied slot against the held key
  always_comb begin
    rank_calc = '0;
    for (int i = 0; i < SLOTS; i++) begin
      le_vec[i] = (CNT_W'(i) < total) && (keys[i] <= key_q);
      eq_vec[i] = (CNT_W'(i) < total) && (keys[i] == key_q);
      rank_calc = rank_calc + CNT_W'(le_vec[i]);
    end
  end

  assign keep       = total >> 1;
  assign cursor_inc = cursor + CNT_W'(1);

  // command capture and compare results
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_q <= cmd_e'(cmd_word.command);
      key_q <= cmd_word.key;
    end
    if (ctrl.load_cmp) begin
      rank  <= rank_calc;
      match <= |eq_vec;
    end
  end

  // key slots: shift larger keys up and drop the new one in place
  always_ff @(posedge clk) begin
    if (ctrl.exec && cmd_q == CMD_INSERT && !match && total < CNT_W'(SLOTS)) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (CNT_W'(i) > rank) begin
          keys[i] <= keys[(i > 0) ? i - 1 : 0];
        end else if (CNT_W'(i) == rank) begin
          keys[i] <= key_q;
        end
      end
    end
  end

  // key count
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (ctrl.exec) begin
      if (cmd_q == CMD_INSERT && !match && total < CNT_W'(SLOTS)) begin
        total <= total + CNT_W'(1);
      end else if (cmd_q == CMD_SPLIT) begin
        total <= keep;
      end
    end
  end

  // result word and split cursor
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      res_q.result_kind <= KIND_REPLY;
      res_q.key_out     <= '0;
      res_q.position    <= '0;
      res_q.found       <= 1'b0;
      res_q.key_count   <= total;
      res_q.needs_split <= (total > CNT_W'(MAX_KEYS));
      res_q.status      <= STAT_OK;
      res_q.last        <= 1'b1;
      unique case (cmd_q)
        CMD_INSERT: begin
          if (match) begin
            res_q.status   <= STAT_DUP;
            res_q.position <= POS_W'(rank - CNT_W'(1));
          end else if (total >= CNT_W'(SLOTS)) begin
            res_q.status   <= STAT_FULL;
            res_q.position <= POS_W'(rank);
          end else begin
            res_q.position    <= POS_W'(rank);
            res_q.key_count   <= total + CNT_W'(1);
            res_q.needs_split <= ((total + CNT_W'(1)) > CNT_W'(MAX_KEYS));
          end
        end
        CMD_SEARCH: begin
          res_q.position <= (rank == '0) ? '0 : POS_W'(rank - CNT_W'(1));
          res_q.found    <= match;
        end
        CMD_SPLIT: begin
          if (total == '0) begin
            res_q.status <= STAT_EMPTY;
          end else begin
            res_q.result_kind <= KIND_SEP;
            res_q.key_out     <= keys[keep[IDX_W-1:0]];
            res_q.position    <= POS_W'(keep);
            res_q.key_count   <= keep;
            res_q.needs_split <= (keep > CNT_W'(MAX_KEYS));
            res_q.last        <= ((keep + CNT_W'(1)) >= total);
          end
        end
        CMD_NONE: begin
          res_q.status <= STAT_OK;
        end
        default: res_q.status <= STAT_OK;
      endcase
      cursor    <= keep + CNT_W'(1);
      split_end <= total;
      move_idx  <= '0;
    end else if (ctrl.emit_next) begin
      // next key of the upper run
      res_q.result_kind <= KIND_MOVED;
      res_q.key_out     <= keys[cursor[IDX_W-1:0]];
      res_q.position    <= move_idx;
      res_q.found       <= 1'b0;
      res_q.key_count   <= total;
      res_q.needs_split <= (total > CNT_W'(MAX_KEYS));
      res_q.status      <= STAT_OK;
      res_q.last        <= (cursor_inc == split_end);
      cursor            <= cursor_inc;
      move_idx          <= move_idx + POS_W'(1);
    end
  end

  assign res_word      = res_q;
  assign stat.out_last = res_q.last;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(SLOTS))
    else $error("key count beyond slot count");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit_next |-> (cursor < split_end))
    else $error("split cursor ran past the upper run");
`endif

endmodule

// ----- rtl/sorted_key_node_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_key_node_unit
// One B-tree node kept as a sorted array of signed keys with a spare slot:
// insert, search and split, with count and needs-split on every result.
// ----------------------------------------------------------------------------
// For an insert or search the sequencer accepts the command word, compares
// the key against all nine slots in parallel and ranks it, shift-inserts
// and builds the result, and hands the result word out, each in a state of
// its own. A split hands out 1 to 5 result words.
// Only one command is in the node at a time; the next is accepted after
// the result word marked last is taken. Key slots need no clearing after
// reset; only slots below the key count are ever read.
module sorted_key_node_unit
  import skn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_word_t cmd_word,
  output logic      res_valid,
  input  logic      res_ready,
  output res_word_t res_word
);

  ctrl_t ctrl;
  stat_t stat;

  // sequencer
  skn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // key slots and result word
  skn_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd_word (cmd_word),
    .ctrl     (ctrl),
    .stat     (stat),
    .res_word (res_word)
  );

endmodule
